@@ hw/rtl/ffdd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Flat-flow disconnect detector package
// Shared constants, lookup tables and small types for the detector.
// ----------------------------------------------------------------------------
package ffdd_pkg;

    // Operation codes of the shared add/subtract unit.
    typedef logic alu_op_t;
    localparam alu_op_t ALU_ADD = 1'b0;
    localparam alu_op_t ALU_SUB = 1'b1;

    // Register map: byte address of the frequency register.
    localparam logic [1:0] REG_OSC_FREQ_ADDR = 2'd0;
    localparam logic [4:0] OSC_FREQ_RESET    = 5'd10;

    // Usable frequency range; the register value is clamped into it.
    localparam logic [4:0] FREQ_MIN = 5'd5;
    localparam logic [4:0] FREQ_MAX = 5'd17;
    localparam int         FREQ_STEPS = 13;

    // Window length and required number of close samples, per frequency.
    localparam logic [7:0] WIN_LEN_TAB [FREQ_STEPS] =
        '{8'd30, 8'd28, 8'd22, 8'd20, 8'd18, 8'd16, 8'd14,
          8'd12, 8'd12, 8'd10, 8'd10, 8'd10, 8'd8};
    localparam logic [3:0] CHECK_TAB [FREQ_STEPS] =
        '{4'd12, 4'd10, 4'd8, 4'd6, 4'd6, 4'd6, 4'd6,
          4'd6, 4'd6, 4'd5, 4'd5, 4'd4, 4'd4};

    // Detection thresholds.
    localparam int         FLAT_MARGIN    = 50;
    localparam int         OVER_RANGE_ABS = 3000;
    localparam logic [8:0] PERIOD_LAST    = 9'd250;
    localparam logic [8:0] HOLD_LAST      = 9'd500;

endpackage
`default_nettype wire

@@ hw/rtl/ffdd_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Flat-flow disconnect detector stream interfaces
// Valid/ready channels for flow ticks in and detector status out.
// ----------------------------------------------------------------------------
interface ffdd_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic                          sample_valid;
    logic signed [SAMPLE_BITS-1:0] flow_sample;

    modport source (output valid, command, sample_valid, flow_sample, input ready);
    modport sink   (input valid, command, sample_valid, flow_sample, output ready);
endinterface

interface ffdd_out_if;
    logic valid;
    logic ready;
    logic disconnect_alarm;
    logic flat_seen;
    logic overflow_seen;

    modport source (output valid, disconnect_alarm, flat_seen, overflow_seen, input ready);
    modport sink   (input valid, disconnect_alarm, flat_seen, overflow_seen, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/ffdd_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ffdd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 30
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ hw/rtl/ffdd_alu.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Flat-flow disconnect detector shared adder
// Signed add or subtract used for summing, division steps and differences.
// ----------------------------------------------------------------------------
module ffdd_alu #(
    parameter int WIDTH = 21
) (
    input  wire ffdd_pkg::alu_op_t         op,
    input  wire logic signed [WIDTH-1:0]   a,
    input  wire logic signed [WIDTH-1:0]   b,
    output logic signed      [WIDTH-1:0]   y
);

    always_comb
    begin
        case (op)
            ffdd_pkg::ALU_SUB: y = a - b;
            default:           y = a + b;
        endcase
    end

endmodule
`default_nettype wire

@@ hw/rtl/flat_flow_disconnect_detector_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Flat-flow disconnect detector
// Detects a disconnected patient tube from a flat, over-range flow pattern.
// ----------------------------------------------------------------------------
// Each transfer on the input channel is one servo tick and yields exactly one
// status transfer on the output channel. A sample tick stores the flow sample
// in a circular window, forms the window mean (truncated toward zero) and
// counts the entries lying within 50 of it; the window length and the
// required count come from the oscillation frequency register. One shared
// add/subtract unit does the summing, division and difference arithmetic
// under a small sequencer. A valid sample passes through the write, sum,
// magnitude, division, sign, close-count and update states to the final
// state before its result is offered; the two walks over the window through
// the single read port of the window memory and the one-bit-per-cycle
// division set how long that takes. A clear command or an ignored sample
// goes straight from idle to the final state. The input is ready only while
// the sequencer is idle; the result sits in an output register, so the next
// tick may be taken while it waits, and a second result then waits in the
// final sequencer state until the register is free. Window entries carry
// valid bits in flip-flops, so reset and the clear command empty the window
// at once, with no clearing pass.
// ----------------------------------------------------------------------------
module flat_flow_disconnect_detector_unit #(
    parameter int WINDOW_MAX  = 30,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // Streams
    ffdd_in_if.sink          in_ch,
    ffdd_out_if.source       out_ch
);

    // ------------------------------------------------------------------------
    // Derived widths
    // ------------------------------------------------------------------------
    localparam int IDX_W = $clog2(WINDOW_MAX);       // window address
    localparam int LEN_W = $clog2(WINDOW_MAX + 1);   // window length / counts
    localparam int SUM_W = SAMPLE_BITS + LEN_W;      // window sum, signed
    localparam int ALU_W = SUM_W;
    localparam int DCW   = $clog2(SAMPLE_BITS + 1);  // division step counter
    localparam logic [7:0] WMAX8 = 8'(WINDOW_MAX);

    // ------------------------------------------------------------------------
    // Sequencer states
    // ------------------------------------------------------------------------
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_WRITE  = 4'd1;
    localparam logic [3:0] ST_SUM    = 4'd2;
    localparam logic [3:0] ST_ABS    = 4'd3;
    localparam logic [3:0] ST_DIV    = 4'd4;
    localparam logic [3:0] ST_SIGN   = 4'd5;
    localparam logic [3:0] ST_CLOSE  = 4'd6;
    localparam logic [3:0] ST_UPDATE = 4'd7;
    localparam logic [3:0] ST_DONE   = 4'd8;

    // ------------------------------------------------------------------------
    // Control registers (reset)
    // ------------------------------------------------------------------------
    logic [3:0]            state_reg,       state_next;
    logic [4:0]            osc_reg,         osc_next;
    logic [IDX_W-1:0]      wp_reg,          wp_next;
    logic [WINDOW_MAX-1:0] valid_reg,       valid_next;
    logic [LEN_W-1:0]      rd_cnt_reg,      rd_cnt_next;
    logic                  rd_pend_reg,     rd_pend_next;
    logic [DCW-1:0]        div_cnt_reg,     div_cnt_next;
    logic [7:0]            period_reg,      period_next;
    logic [7:0]            over_ticks_reg,  over_ticks_next;
    logic [7:0]            flat_ticks_reg,  flat_ticks_next;
    logic                  over_flag_reg,   over_flag_next;
    logic                  flat_flag_reg,   flat_flag_next;
    logic [8:0]            raise_reg,       raise_next;
    logic [8:0]            release_reg,     release_next;
    logic                  alarm_reg,       alarm_next;
    logic                  out_valid_reg,   out_valid_next;

    // ------------------------------------------------------------------------
    // Working registers (no reset)
    // ------------------------------------------------------------------------
    logic [LEN_W-1:0]              len_reg,       len_next;
    logic [3:0]                    chk_reg,       chk_next;
    logic [2:0]                    fq4_reg,       fq4_next;
    logic signed [SAMPLE_BITS-1:0] flow_reg,      flow_next;
    logic                          over_hit_reg,  over_hit_next;
    logic signed [SUM_W-1:0]       acc_reg,       acc_next;
    logic                          vld_rd_reg,    vld_rd_next;
    logic                          neg_reg,       neg_next;
    logic [LEN_W-1:0]              rem_reg,       rem_next;
    logic [SAMPLE_BITS-1:0]        quo_reg,       quo_next;
    logic signed [SAMPLE_BITS:0]   mean_reg,      mean_next;
    logic [LEN_W-1:0]              close_cnt_reg, close_cnt_next;
    logic                          out_alarm_reg, out_alarm_next;
    logic                          out_flat_reg,  out_flat_next;
    logic                          out_over_reg,  out_over_next;

    // ------------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------------
    logic                          in_xfer;
    logic                          cfg_wr;
    logic [4:0]                    freq_clamped;
    logic [3:0]                    tab_idx;
    logic [7:0]                    tab_len;
    logic [SAMPLE_BITS-1:0]        ram_rdata;
    logic signed [SAMPLE_BITS-1:0] win_x;
    logic                          rd_issue;
    logic [LEN_W:0]                wp_inc;
    logic [LEN_W:0]                rem_sh;
    logic                          div_ge;
    logic [SUM_W-1:0]              sum_mag;

    ffdd_pkg::alu_op_t             alu_op;
    logic signed [ALU_W-1:0]       alu_a;
    logic signed [ALU_W-1:0]       alu_b;
    logic signed [ALU_W-1:0]       alu_y;

    logic [7:0]                    upd_flat_ticks;
    logic [7:0]                    upd_over_ticks;
    logic [8:0]                    upd_period;
    logic                          upd_over_flag;
    logic                          upd_flat_flag;
    logic [8:0]                    upd_raise;
    logic [8:0]                    upd_release;

    // ------------------------------------------------------------------------
    // Configuration port. Writes are registered; reads are
    // combinational, so pready is always high.
    // ------------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ffdd_pkg::REG_OSC_FREQ_ADDR);
    assign prdata = (paddr == ffdd_pkg::REG_OSC_FREQ_ADDR) ? 32'(osc_reg) : 32'd0;

    // ------------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------------
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_xfer     = in_ch.valid && in_ch.ready;

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.disconnect_alarm = out_alarm_reg;
    assign out_ch.flat_seen        = out_flat_reg;
    assign out_ch.overflow_seen    = out_over_reg;

    // ------------------------------------------------------------------------
    // Frequency lookup. The register is clamped into the table range and the
    // window length is limited to the storage depth.
    // ------------------------------------------------------------------------
    always_comb
    begin
        if (osc_reg < ffdd_pkg::FREQ_MIN)
        begin
            freq_clamped = ffdd_pkg::FREQ_MIN;
        end
        else if (osc_reg > ffdd_pkg::FREQ_MAX)
        begin
            freq_clamped = ffdd_pkg::FREQ_MAX;
        end
        else
        begin
            freq_clamped = osc_reg;
        end
        tab_idx = 4'(freq_clamped - ffdd_pkg::FREQ_MIN);
        tab_len = ffdd_pkg::WIN_LEN_TAB[tab_idx];
        if (tab_len > WMAX8)
        begin
            tab_len = WMAX8;
        end
    end

    // ------------------------------------------------------------------------
    // Window memory. An entry that has not been written since reset or the
    // last clear reads as zero through its valid bit.
    // ------------------------------------------------------------------------
    ffdd_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_MAX)
    ) u_window (
        .clk   (clk),
        .we    (state_reg == ST_WRITE),
        .waddr (wp_reg),
        .wdata (flow_reg),
        .raddr (rd_cnt_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign win_x    = vld_rd_reg ? $signed(ram_rdata) : '0;
    assign rd_issue = (rd_cnt_reg < len_reg);

    // ------------------------------------------------------------------------
    // Shared add/subtract unit and its operand selection.
    // ------------------------------------------------------------------------
    assign rem_sh = {rem_reg, quo_reg[SAMPLE_BITS-1]};

    always_comb
    begin
        alu_op = ffdd_pkg::ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
        unique case (state_reg)
            ST_SUM:
            begin
                alu_op = ffdd_pkg::ALU_ADD;
                alu_a  = acc_reg;
                alu_b  = ALU_W'(win_x);
            end
            ST_ABS:
            begin
                alu_op = ffdd_pkg::ALU_SUB;
                alu_b  = acc_reg;
            end
            ST_DIV:
            begin
                alu_op = ffdd_pkg::ALU_SUB;
                alu_a  = $signed(ALU_W'(rem_sh));
                alu_b  = $signed(ALU_W'(len_reg));
            end
            ST_SIGN:
            begin
                alu_op = ffdd_pkg::ALU_SUB;
                alu_b  = $signed(ALU_W'(quo_reg));
            end
            ST_CLOSE:
            begin
                alu_op = ffdd_pkg::ALU_SUB;
                alu_a  = ALU_W'(mean_reg);
                alu_b  = ALU_W'(win_x);
            end
            default:
            begin
                alu_op = ffdd_pkg::ALU_ADD;
            end
        endcase
    end

    ffdd_alu #(
        .WIDTH (ALU_W)
    ) u_alu (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .y  (alu_y)
    );

    assign div_ge  = !alu_y[ALU_W-1];
    assign sum_mag = acc_reg[SUM_W-1] ? alu_y : acc_reg;
    assign wp_inc  = (LEN_W + 1)'(wp_reg) + 1'b1;

    // ------------------------------------------------------------------------
    // End-of-tick bookkeeping: flat and over-range counts, the evaluation
    // period of 251 valid samples, and the raise/release hold counters.
    // ------------------------------------------------------------------------
    always_comb
    begin
        upd_flat_ticks = flat_ticks_reg
                       + ((close_cnt_reg >= LEN_W'(chk_reg)) ? 8'd1 : 8'd0);
        upd_over_ticks = over_ticks_reg + (over_hit_reg ? 8'd1 : 8'd0);
        upd_period     = 9'(period_reg) + 9'd1;
        upd_over_flag  = over_flag_reg;
        upd_flat_flag  = flat_flag_reg;
        if (upd_period > ffdd_pkg::PERIOD_LAST)
        begin
            upd_over_flag  = (upd_over_ticks > 8'(fq4_reg));
            upd_flat_flag  = (upd_flat_ticks > 8'(fq4_reg));
            upd_over_ticks = '0;
            upd_flat_ticks = '0;
            upd_period     = '0;
        end
        if (upd_over_flag && upd_flat_flag)
        begin
            upd_raise   = raise_reg + 9'd1;
            upd_release = '0;
        end
        else
        begin
            upd_raise   = '0;
            upd_release = release_reg + 9'd1;
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        osc_next        = osc_reg;
        wp_next         = wp_reg;
        valid_next      = valid_reg;
        rd_cnt_next     = rd_cnt_reg;
        rd_pend_next    = 1'b0;
        div_cnt_next    = div_cnt_reg;
        period_next     = period_reg;
        over_ticks_next = over_ticks_reg;
        flat_ticks_next = flat_ticks_reg;
        over_flag_next  = over_flag_reg;
        flat_flag_next  = flat_flag_reg;
        raise_next      = raise_reg;
        release_next    = release_reg;
        alarm_next      = alarm_reg;
        out_valid_next  = out_valid_reg;

        len_next        = len_reg;
        chk_next        = chk_reg;
        fq4_next        = fq4_reg;
        flow_next       = flow_reg;
        over_hit_next   = over_hit_reg;
        acc_next        = acc_reg;
        vld_rd_next     = valid_reg[rd_cnt_reg[IDX_W-1:0]];
        neg_next        = neg_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        mean_next       = mean_reg;
        close_cnt_next  = close_cnt_reg;
        out_alarm_next  = out_alarm_reg;
        out_flat_next   = out_flat_reg;
        out_over_next   = out_over_reg;

        if (cfg_wr)
        begin
            osc_next = pwdata[4:0];
        end

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    len_next      = LEN_W'(tab_len);
                    chk_next      = ffdd_pkg::CHECK_TAB[tab_idx];
                    fq4_next      = freq_clamped[4:2];
                    flow_next     = in_ch.flow_sample;
                    over_hit_next = (in_ch.flow_sample > ffdd_pkg::OVER_RANGE_ABS)
                                 || (in_ch.flow_sample < -ffdd_pkg::OVER_RANGE_ABS);
                    if (in_ch.command)
                    begin
                        // Clear command: the whole detector state returns to
                        // its reset value; the register is kept.
                        wp_next         = '0;
                        valid_next      = '0;
                        period_next     = '0;
                        over_ticks_next = '0;
                        flat_ticks_next = '0;
                        over_flag_next  = 1'b0;
                        flat_flag_next  = 1'b0;
                        raise_next      = '0;
                        release_next    = '0;
                        alarm_next      = 1'b0;
                        state_next      = ST_DONE;
                    end
                    else if (in_ch.sample_valid)
                    begin
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_WRITE:
            begin
                // After the window has shrunk the write position may lie
                // beyond its end; that entry is written once and the position
                // wraps to the start as soon as it reaches the window length.
                valid_next[wp_reg] = 1'b1;
                wp_next     = (wp_inc >= (LEN_W + 1)'(len_reg)) ? '0 : wp_inc[IDX_W-1:0];
                acc_next    = '0;
                rd_cnt_next = '0;
                state_next  = ST_SUM;
            end

            ST_SUM:
            begin
                if (rd_issue)
                begin
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                end
                rd_pend_next = rd_issue;
                if (rd_pend_reg)
                begin
                    acc_next = alu_y;
                end
                if (!rd_issue && !rd_pend_reg)
                begin
                    state_next = ST_ABS;
                end
            end

            ST_ABS:
            begin
                // The magnitude of the sum is below len * 2^SAMPLE_BITS, so
                // the quotient needs SAMPLE_BITS bits and the upper part
                // already starts as a partial remainder smaller than len.
                neg_next     = acc_reg[SUM_W-1];
                rem_next     = sum_mag[SUM_W-1:SAMPLE_BITS];
                quo_next     = sum_mag[SAMPLE_BITS-1:0];
                div_cnt_next = DCW'(SAMPLE_BITS);
                state_next   = ST_DIV;
            end

            ST_DIV:
            begin
                // One restoring division step a cycle.
                rem_next     = div_ge ? alu_y[LEN_W-1:0] : rem_sh[LEN_W-1:0];
                quo_next     = {quo_reg[SAMPLE_BITS-2:0], div_ge};
                div_cnt_next = div_cnt_reg - 1'b1;
                if (div_cnt_reg == DCW'(1))
                begin
                    state_next = ST_SIGN;
                end
            end

            ST_SIGN:
            begin
                // Division truncates toward zero: the sign is put back on
                // the magnitude quotient.
                mean_next      = neg_reg ? alu_y[SAMPLE_BITS:0] : $signed({1'b0, quo_reg});
                rd_cnt_next    = '0;
                close_cnt_next = '0;
                state_next     = ST_CLOSE;
            end

            ST_CLOSE:
            begin
                if (rd_issue)
                begin
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                end
                rd_pend_next = rd_issue;
                if (rd_pend_reg && (alu_y < ffdd_pkg::FLAT_MARGIN)
                                && (alu_y > -ffdd_pkg::FLAT_MARGIN))
                begin
                    close_cnt_next = close_cnt_reg + 1'b1;
                end
                if (!rd_issue && !rd_pend_reg)
                begin
                    state_next = ST_UPDATE;
                end
            end

            ST_UPDATE:
            begin
                flat_ticks_next = upd_flat_ticks;
                over_ticks_next = upd_over_ticks;
                period_next     = upd_period[7:0];
                over_flag_next  = upd_over_flag;
                flat_flag_next  = upd_flat_flag;
                raise_next      = upd_raise;
                release_next    = upd_release;
                if (upd_raise > ffdd_pkg::HOLD_LAST)
                begin
                    alarm_next = 1'b1;
                    raise_next = '0;
                end
                if (upd_release > ffdd_pkg::HOLD_LAST)
                begin
                    alarm_next   = 1'b0;
                    release_next = '0;
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                // Hand the status to the output register once it is free.
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_alarm_next = alarm_reg;
                    out_flat_next  = flat_flag_reg;
                    out_over_next  = over_flag_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            osc_reg        <= ffdd_pkg::OSC_FREQ_RESET;
            wp_reg         <= '0;
            valid_reg      <= '0;
            rd_cnt_reg     <= '0;
            rd_pend_reg    <= 1'b0;
            div_cnt_reg    <= '0;
            period_reg     <= '0;
            over_ticks_reg <= '0;
            flat_ticks_reg <= '0;
            over_flag_reg  <= 1'b0;
            flat_flag_reg  <= 1'b0;
            raise_reg      <= '0;
            release_reg    <= '0;
            alarm_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            osc_reg        <= osc_next;
            wp_reg         <= wp_next;
            valid_reg      <= valid_next;
            rd_cnt_reg     <= rd_cnt_next;
            rd_pend_reg    <= rd_pend_next;
            div_cnt_reg    <= div_cnt_next;
            period_reg     <= period_next;
            over_ticks_reg <= over_ticks_next;
            flat_ticks_reg <= flat_ticks_next;
            over_flag_reg  <= over_flag_next;
            flat_flag_reg  <= flat_flag_next;
            raise_reg      <= raise_next;
            release_reg    <= release_next;
            alarm_reg      <= alarm_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg       <= len_next;
        chk_reg       <= chk_next;
        fq4_reg       <= fq4_next;
        flow_reg      <= flow_next;
        over_hit_reg  <= over_hit_next;
        acc_reg       <= acc_next;
        vld_rd_reg    <= vld_rd_next;
        neg_reg       <= neg_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        mean_reg      <= mean_next;
        close_cnt_reg <= close_cnt_next;
        out_alarm_reg <= out_alarm_next;
        out_flat_reg  <= out_flat_next;
        out_over_reg  <= out_over_next;
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // A clear command leaves the alarm, the period and the window empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && in_ch.command |=> !alarm_reg && (period_reg == '0) && (valid_reg == '0))
        else $error("clear command did not empty the detector state");

    // The partial remainder stays below the divisor throughout the division.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < len_reg))
        else $error("division remainder out of range");

    // The close count can never exceed the window length.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE) |-> (close_cnt_reg <= len_reg))
        else $error("close count exceeds window length");

    // A result appears only on leaving the final sequencer state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the final state");

endmodule
`default_nettype wire

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// Flat-flow disconnect detector testbench
// Drives flow ticks and frequency settings into the detector, predicts every
// status transfer with an independent model of the detector and checks each
// status field, with random gaps on both channels and a long receiver stall.
// ----------------------------------------------------------------------------
module tb;

    localparam int SAMPLE_BITS      = 16;
    localparam int WINDOW_DEPTH     = 30;
    localparam int FREQ_LO          = 5;
    localparam int FREQ_HI          = 17;
    localparam int FLAT_BAND        = 50;
    localparam int OVER_LIMIT       = 3000;
    localparam int PERIOD_LAST_TICK = 250;
    localparam int HOLD_LAST_TICK   = 500;

    // Command codes carried by the command field of a tick.
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // Run limits.
    localparam int CYCLE_LIMIT     = 2_500_000;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int DRAIN_CYCLES    = 200;

    typedef struct {
        logic                          command;
        logic                          sample_valid;
        logic signed [SAMPLE_BITS-1:0] flow;
    } tick_t;

    typedef struct {
        logic alarm;
        logic flat;
        logic over;
    } status_t;

    // Shapes of the flow trace used to build the random part.
    typedef enum int {
        SHAPE_FLAT_HIGH,
        SHAPE_FLAT_LOW,
        SHAPE_NOISE,
        SHAPE_EDGE
    } flow_shape_t;

    // Clock, reset and configuration port, all known from time zero.
    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [1:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // Locally held channel drives, fed into the interfaces below.
    logic                          tick_valid        = 1'b0;
    logic                          tick_command      = CMD_TICK;
    logic                          tick_sample_valid = 1'b0;
    logic signed [SAMPLE_BITS-1:0] tick_flow         = '0;
    logic                          status_ready      = 1'b0;

    ffdd_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) tick_ch ();
    ffdd_out_if                             status_ch ();

    assign tick_ch.valid        = tick_valid;
    assign tick_ch.command      = tick_command;
    assign tick_ch.sample_valid = tick_sample_valid;
    assign tick_ch.flow_sample  = tick_flow;
    assign status_ch.ready      = status_ready;

    // Ticks waiting to be offered, and status transfers still owed by the block.
    tick_t   tick_queue [$];
    status_t status_due [$];
    tick_t   tick_on_bus;
    status_t status_want;

    // Predicted detector state, kept apart from anything inside the block.
    int         flow_hist [WINDOW_DEPTH];
    int         win_pos;
    int         period_count;
    int         raise_count;
    int         release_count;
    logic [7:0] over_count;
    logic [7:0] flat_count;
    logic       over_state;
    logic       flat_state;
    logic       alarm_state;
    logic [4:0] freq_setting;

    // Handshake pacing shared between the stimulus and the two channel processes.
    bit steady_flow;
    int send_gap;
    int take_gap;
    int hold_left;
    int hold_off_asked;
    int hold_off_served;

    // Bookkeeping for the verdict and the closing summary.
    int mismatches;
    int cycle_count;
    int ticks_taken;
    int samples_seen;
    int ignored_seen;
    int clears_seen;
    int statuses_checked;
    int alarm_raises;
    int alarm_drops;
    int settings_used;

    flat_flow_disconnect_detector_unit #(
        .WINDOW_MAX  (WINDOW_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (tick_ch),
        .out_ch  (status_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 70);
    endfunction

    function automatic void note_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= 10)
            $display("tb: mismatch on %s: expected %0d, got %0d", what, want, got);
    endfunction

    // Reset and the clear command both empty the whole detector; the frequency
    // setting is not part of it.
    function automatic void clear_detector();
        for (int i = 0; i < WINDOW_DEPTH; i++)
            flow_hist[i] = 0;
        win_pos       = 0;
        period_count  = 0;
        raise_count   = 0;
        release_count = 0;
        over_count    = '0;
        flat_count    = '0;
        over_state    = 1'b0;
        flat_state    = 1'b0;
        alarm_state   = 1'b0;
    endfunction

    // Advances the predicted detector by one accepted tick and returns the
    // status that the block must report for it.
    function automatic status_t predict_status(input tick_t t);
        int      f;
        int      span;
        int      need;
        int      total;
        int      avg;
        int      diff;
        int      near;
        int      mag;
        status_t status;
        if (t.command == CMD_CLEAR)
        begin
            clear_detector();
            clears_seen++;
        end
        else if (!t.sample_valid)
        begin
            ignored_seen++;
        end
        else
        begin
            samples_seen++;
            // Out-of-range settings are pinned to the table ends, for freq/4 too.
            f = freq_setting;
            if (f < FREQ_LO)
                f = FREQ_LO;
            if (f > FREQ_HI)
                f = FREQ_HI;
            case (f)
                5:       begin span = 30; need = 12; end
                6:       begin span = 28; need = 10; end
                7:       begin span = 22; need = 8;  end
                8:       begin span = 20; need = 6;  end
                9:       begin span = 18; need = 6;  end
                10:      begin span = 16; need = 6;  end
                11:      begin span = 14; need = 6;  end
                12:      begin span = 12; need = 6;  end
                13:      begin span = 12; need = 6;  end
                14:      begin span = 10; need = 5;  end
                15:      begin span = 10; need = 5;  end
                16:      begin span = 10; need = 4;  end
                default: begin span = 8;  need = 4;  end
            endcase
            if (span > WINDOW_DEPTH)
                span = WINDOW_DEPTH;

            // The write position may lie beyond a window that has just shrunk;
            // it then writes there once and wraps to the start.
            if (win_pos >= WINDOW_DEPTH)
                win_pos = 0;
            flow_hist[win_pos] = t.flow;
            win_pos++;
            if (win_pos >= span)
                win_pos = 0;

            // The mean is truncated toward zero, as integer division does.
            total = 0;
            for (int i = 0; i < span; i++)
                total += flow_hist[i];
            avg = total / span;
            near = 0;
            for (int i = 0; i < span; i++)
            begin
                diff = avg - flow_hist[i];
                if (diff < 0)
                    diff = -diff;
                if (diff < FLAT_BAND)
                    near++;
            end
            if (near >= need)
                flat_count++;

            mag = t.flow;
            if (mag < 0)
                mag = -mag;
            if (mag > OVER_LIMIT)
                over_count++;

            period_count++;
            if (period_count > PERIOD_LAST_TICK)
            begin
                over_state   = over_count > (f >> 2);
                flat_state   = flat_count > (f >> 2);
                over_count   = '0;
                flat_count   = '0;
                period_count = 0;
            end

            if (over_state && flat_state)
            begin
                raise_count++;
                release_count = 0;
            end
            else
            begin
                raise_count = 0;
                release_count++;
            end
            if (raise_count > HOLD_LAST_TICK)
            begin
                if (!alarm_state)
                    alarm_raises++;
                alarm_state = 1'b1;
                raise_count = 0;
            end
            if (release_count > HOLD_LAST_TICK)
            begin
                if (alarm_state)
                    alarm_drops++;
                alarm_state   = 1'b0;
                release_count = 0;
            end
        end
        status.alarm = alarm_state;
        status.flat  = flat_state;
        status.over  = over_state;
        return status;
    endfunction

    function automatic void queue_tick(input logic command, input logic sample_valid,
                                       input int flow_val);
        tick_t t;
        t.command      = command;
        t.sample_valid = sample_valid;
        t.flow         = flow_val[SAMPLE_BITS-1:0];
        tick_queue.push_back(t);
    endfunction

    // Sender: offers queued ticks, predicts each one as its transfer completes,
    // and leaves a random gap after it unless the phase runs without idling.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (tick_valid && tick_ch.ready)
            begin
                status_due.push_back(predict_status(tick_on_bus));
                ticks_taken++;
            end
            if (!tick_valid || tick_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    tick_valid <= 1'b0;
                end
                else if (tick_queue.size() != 0)
                begin
                    tick_on_bus = tick_queue.pop_front();
                    tick_valid        <= 1'b1;
                    tick_command      <= tick_on_bus.command;
                    tick_sample_valid <= tick_on_bus.sample_valid;
                    tick_flow         <= tick_on_bus.flow;
                    send_gap = steady_flow ? 0 : pick_gap();
                end
                else
                begin
                    tick_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks every status transfer against the oldest prediction.
    // A requested hold-off keeps ready low for a long stretch so that the
    // block fills up and has to stall its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_ready <= 1'b0;
            take_gap  = 0;
            hold_left = 0;
        end
        else
        begin
            if (status_ch.valid && status_ready)
            begin
                statuses_checked++;
                if (status_due.size() == 0)
                begin
                    note_mismatch("status transfer with no tick pending", -1,
                                  {status_ch.disconnect_alarm, status_ch.flat_seen,
                                   status_ch.overflow_seen});
                end
                else
                begin
                    status_want = status_due.pop_front();
                    if (status_ch.disconnect_alarm !== status_want.alarm)
                        note_mismatch("disconnect_alarm", status_want.alarm,
                                      status_ch.disconnect_alarm);
                    if (status_ch.flat_seen !== status_want.flat)
                        note_mismatch("flat_seen", status_want.flat, status_ch.flat_seen);
                    if (status_ch.overflow_seen !== status_want.over)
                        note_mismatch("overflow_seen", status_want.over,
                                      status_ch.overflow_seen);
                end
                take_gap = steady_flow ? 0 : pick_gap();
            end
            if (hold_off_asked != hold_off_served)
            begin
                hold_left = HOLD_OFF_CYCLES;
                hold_off_served++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                status_ready <= 1'b0;
            end
            else if (take_gap > 0)
            begin
                take_gap--;
                status_ready <= 1'b0;
            end
            else
            begin
                status_ready <= 1'b1;
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: no completion within %0d cycles", CYCLE_LIMIT);
            $display("tb failed");
            $finish;
        end
    end

    // One APB transfer on the frequency register: a setup phase, then an
    // access phase that completes at the first edge with pready high.
    task automatic apb_access(input logic write_op, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write_op;
        paddr   <= ffdd_pkg::REG_OSC_FREQ_ADDR;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Writes a new frequency, with random bits above the field, and reads it back.
    task automatic set_frequency(input logic [4:0] freq);
        logic [31:0] wdata;
        logic [31:0] readback;
        wdata      = $urandom;
        wdata[4:0] = freq;
        apb_access(1'b1, wdata, readback);
        freq_setting = freq;
        settings_used++;
        apb_access(1'b0, 32'd0, readback);
        if (readback !== {27'd0, freq})
            note_mismatch("osc_freq_hz read-back", freq, readback);
    endtask

    // Blocks until every queued tick has been taken and every status transfer
    // it owes has arrived, so the block is idle afterwards.
    task automatic wait_quiet();
        while (tick_queue.size() != 0 || tick_valid || status_due.size() != 0)
            @(posedge clk);
    endtask

    // A phase of random traffic: runs of flow with one shape (steady and above
    // the limit, steady and quiet, raw noise, or values at the boundaries),
    // broken now and then by ignored samples and clear commands.
    task automatic run_mixed_phase(input logic [4:0] freq, input int samples,
                                   input bit steady, input bit squeeze);
        int          left;
        int          chunk;
        int          roll;
        int          base;
        int          value;
        flow_shape_t shape;
        set_frequency(freq);
        steady_flow = steady;
        left = samples;
        while (left > 0)
        begin
            chunk = $urandom_range(4, 40);
            roll  = $urandom_range(0, 99);
            if (roll < 35)
                shape = SHAPE_FLAT_HIGH;
            else if (roll < 65)
                shape = SHAPE_FLAT_LOW;
            else if (roll < 85)
                shape = SHAPE_NOISE;
            else
                shape = SHAPE_EDGE;
            if (shape == SHAPE_FLAT_HIGH)
            begin
                base = $urandom_range(3100, 32000);
                if ($urandom_range(0, 1) == 1)
                    base = -base;
            end
            else
            begin
                base = int'($urandom_range(0, 5800)) - 2900;
            end
            while (chunk > 0 && left > 0)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 2)
                begin
                    queue_tick(CMD_CLEAR, 1'($urandom_range(0, 1)), $urandom);
                end
                else if (roll < 9)
                begin
                    queue_tick(CMD_TICK, 1'b0, $urandom);
                end
                else
                begin
                    case (shape)
                        SHAPE_FLAT_HIGH: value = base + int'($urandom_range(0, 40)) - 20;
                        SHAPE_FLAT_LOW:  value = base + int'($urandom_range(0, 60)) - 30;
                        SHAPE_NOISE:     value = $urandom;
                        default:
                        begin
                            case ($urandom_range(0, 7))
                                0:       value = -32768;
                                1:       value = 32767;
                                2:       value = OVER_LIMIT;
                                3:       value = OVER_LIMIT + 1;
                                4:       value = -OVER_LIMIT;
                                5:       value = -OVER_LIMIT - 1;
                                6:       value = 0;
                                default: value = -1;
                            endcase
                        end
                    endcase
                    queue_tick(CMD_TICK, 1'b1, value);
                    chunk--;
                    left--;
                end
            end
        end
        if (squeeze)
            hold_off_asked++;
        wait_quiet();
    endtask

    initial
    begin
        logic [31:0] readback;
        int          base;
        int          done;

        clear_detector();
        freq_setting = 5'd10;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The register must come out of reset at ten hertz.
        apb_access(1'b0, 32'd0, readback);
        if (readback !== 32'd10)
            note_mismatch("osc_freq_hz after reset", 10, readback);

        // Directed part at ten hertz, a sixteen-entry window. Each single sample
        // on an empty window puts the mean at sample/16: 784 and 800 land it
        // just inside and just on the flat margin, and -799 checks that the
        // mean truncates toward zero rather than rounding down.
        steady_flow = 1'b0;
        queue_tick(CMD_TICK, 1'b1, 784);
        queue_tick(CMD_CLEAR, 1'b0, 0);
        queue_tick(CMD_TICK, 1'b1, 800);
        queue_tick(CMD_CLEAR, 1'b0, 0);
        queue_tick(CMD_TICK, 1'b1, -799);
        queue_tick(CMD_CLEAR, 1'b0, 0);
        queue_tick(CMD_TICK, 1'b1, -800);
        queue_tick(CMD_CLEAR, 1'b0, 0);
        // Extremes of the sample and both sides of the over-range limit.
        queue_tick(CMD_TICK, 1'b1, 32767);
        queue_tick(CMD_TICK, 1'b1, -32768);
        queue_tick(CMD_TICK, 1'b1, 0);
        queue_tick(CMD_TICK, 1'b1, -1);
        queue_tick(CMD_TICK, 1'b1, OVER_LIMIT);
        queue_tick(CMD_TICK, 1'b1, OVER_LIMIT + 1);
        queue_tick(CMD_TICK, 1'b1, -OVER_LIMIT);
        queue_tick(CMD_TICK, 1'b1, -OVER_LIMIT - 1);
        queue_tick(CMD_TICK, 1'b1, OVER_LIMIT - 1);
        // Ignored samples leave the state alone; a clear wins over a valid sample.
        queue_tick(CMD_TICK, 1'b0, 12345);
        queue_tick(CMD_TICK, 1'b0, -32768);
        queue_tick(CMD_CLEAR, 1'b1, 32767);
        queue_tick(CMD_TICK, 1'b1, 2999);
        wait_quiet();

        // Random phases over both table ends and settings outside the range.
        // The window is not cleared between phases, so a shrinking window meets
        // a write position left beyond its end.
        run_mixed_phase(5'd5, 90, 1'b0, 1'b0);
        run_mixed_phase(5'd17, 90, 1'b1, 1'b1);
        run_mixed_phase(5'd0, 80, 1'b0, 1'b0);
        run_mixed_phase(5'd31, 80, 1'b0, 1'b1);
        run_mixed_phase(5'd4, 70, 1'b0, 1'b0);
        run_mixed_phase(5'd18, 70, 1'b1, 1'b0);
        run_mixed_phase(5'($urandom_range(0, 31)), 80, 1'b0, 1'b0);

        // A full disconnect episode from a clean start: steady over-range flow
        // sets both flags at the first evaluation, keeps them through the
        // second, and the alarm rises after the hold count. Ordinary flow then
        // drops the flags at the third evaluation and, after the same hold
        // count, the alarm falls again.
        set_frequency(5'($urandom_range(FREQ_LO, FREQ_HI)));
        steady_flow = 1'b0;
        queue_tick(CMD_CLEAR, 1'b0, 0);
        base = $urandom_range(3100, 30000);
        if ($urandom_range(0, 1) == 1)
            base = -base;
        done = 0;
        while (done < 2 * (PERIOD_LAST_TICK + 1))
        begin
            if ($urandom_range(0, 99) < 3)
            begin
                queue_tick(CMD_TICK, 1'b0, $urandom);
            end
            else
            begin
                queue_tick(CMD_TICK, 1'b1, base + int'($urandom_range(0, 40)) - 20);
                done++;
            end
        end
        done = 0;
        while (done < 770)
        begin
            if ($urandom_range(0, 99) < 3)
            begin
                queue_tick(CMD_TICK, 1'b0, $urandom);
            end
            else
            begin
                queue_tick(CMD_TICK, 1'b1, int'($urandom_range(0, 5800)) - 2900);
                done++;
            end
        end
        wait_quiet();

        run_mixed_phase(5'd12, 60, 1'b0, 1'b0);

        // Let any stray status transfer show itself before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("tb: %0d ticks taken (%0d samples, %0d ignored, %0d clears), %0d statuses checked",
                 ticks_taken, samples_seen, ignored_seen, clears_seen, statuses_checked);
        $display("tb: %0d frequency settings, alarm raised %0d and released %0d times, %0d mismatches",
                 settings_used, alarm_raises, alarm_drops, mismatches);
        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/ffdd_pkg.sv
hw/rtl/ffdd_if.sv
hw/rtl/ffdd_ram.sv
hw/rtl/ffdd_alu.sv
hw/rtl/flat_flow_disconnect_detector_unit.sv
dv/tb.sv
